### hdl/tsrf_pkg.sv
package tsrf_pkg;

    // Belief precision and derived widths
    localparam int BELIEF_FRAC_BITS = 32;
    localparam int BELIEF_W         = BELIEF_FRAC_BITS;
    localparam int PROD_W           = BELIEF_FRAC_BITS + 16;
    localparam int PA_W             = BELIEF_FRAC_BITS + 1;
    localparam int PRED_W           = BELIEF_FRAC_BITS + 2;

    // Divider geometry
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] ZQ_STEPS = DIV_CNT_W'(49);
    localparam logic [DIV_CNT_W-1:0] U_STEPS  = DIV_CNT_W'(64);
    localparam logic [DIV_CNT_W-1:0] F_STEPS  = DIV_CNT_W'(BELIEF_FRAC_BITS);

    // Exp approximation constants (Q.16)
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] EXP_C1    = 17'd45426;
    localparam logic [16:0] EXP_C2    = 17'd15743;
    localparam logic [16:0] EXP_C3    = 17'd3638;
    localparam logic [16:0] EXP_ONE   = 17'd65536;

    localparam logic [15:0] P_HALF    = 16'd32768;
    localparam logic [16:0] THR_RESET = 17'd32768;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSITION = 3'd0,
        CFG_MEANS      = 3'd1,
        CFG_DEVIATIONS = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_WARMUP     = 3'd4,
        CFG_INIT_PROBS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] transition;
        logic [63:0] means;
        logic [63:0] deviations;
        logic [16:0] threshold;
        logic [15:0] warmup;
        logic [31:0] init_probs;
    } t_cfg;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_PRED_A,
        OP_PRED_B,
        OP_ZQ_START,
        OP_EXP_T,
        OP_EXP_Y,
        OP_H1,
        OP_H2,
        OP_H3,
        OP_EXP_E,
        OP_U_START,
        OP_U_CAP,
        OP_NORM,
        OP_ALPHA,
        OP_ALPHA_ADD,
        OP_ZSUM,
        OP_F_START,
        OP_FINISH,
        OP_RESTART
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RESTART,
        ST_PRED_A,
        ST_PRED_B,
        ST_ZQ_START,
        ST_ZQ_WAIT,
        ST_EXP_T,
        ST_EXP_Y,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_EXP_E,
        ST_U_START,
        ST_U_WAIT,
        ST_U_CAP,
        ST_NORM,
        ST_ALPHA,
        ST_ALPHA_ADD,
        ST_ZSUM,
        ST_F_START,
        ST_F_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic div_busy;
        logic norm_fits;
    } t_dp_status;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_cmd;

    typedef struct packed {
        logic [31:0] record_count;
        logic [31:0] change_count;
        logic        regime_changed;
        logic        regime_valid;
        logic        regime;
        logic [15:0] p_bull;
    } t_result;

endpackage

### hdl/tsrf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
module tsrf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsrf_pkg::t_div_cmd          i_cmd,
    output logic                        o_busy,
    output logic [tsrf_pkg::DIV_W-1:0]  o_quot
);

    logic [tsrf_pkg::DIV_W-1:0]     r_rem;
    logic [tsrf_pkg::DIV_W-1:0]     r_dvd;
    logic [tsrf_pkg::DIV_W-1:0]     r_dvs;
    logic [tsrf_pkg::DIV_W-1:0]     r_q;
    logic [tsrf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;

    logic [tsrf_pkg::DIV_W:0] w_sh;
    logic [tsrf_pkg::DIV_W:0] w_diff;
    logic                     w_ge;

    // Partial remainder with the next dividend bit shifted in
    always_comb begin
        w_sh   = {r_rem, r_dvd[tsrf_pkg::DIV_W-1]};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_diff = w_sh - {1'b0, r_dvs};
    end

    // Control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tsrf_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder, dividend and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.rem_init;
            r_dvd <= i_cmd.dividend;
            r_dvs <= i_cmd.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[tsrf_pkg::DIV_W-1:0] : w_sh[tsrf_pkg::DIV_W-1:0];
            r_dvd <= {r_dvd[tsrf_pkg::DIV_W-2:0], 1'b0};
            r_q   <= {r_q[tsrf_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("divider started while busy");

    a_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_cnt) == tsrf_pkg::DIV_CNT_W'(1))
        else $error("divider stopped early");

endmodule

### hdl/tsrf_dp.sv
// Filter datapath: prediction, Gaussian weights, normalization, regime logic
module tsrf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsrf_pkg::t_dp_op     i_op,
    input  logic [31:0]          i_sample,
    input  tsrf_pkg::t_cfg       i_cfg,
    output tsrf_pkg::t_dp_status o_status,
    output tsrf_pkg::t_result    o_result
);

    localparam int BW = tsrf_pkg::BELIEF_W;
    localparam int F  = tsrf_pkg::BELIEF_FRAC_BITS;

    // Filter state
    logic [BW-1:0] r_belief [2];
    logic          r_last_regime;
    logic          r_last_valid;
    logic [31:0]   r_records;
    logic [31:0]   r_changes;

    // Per-item working registers, one lane per state
    logic [31:0]                  r_x;
    logic [32:0]                  r_ad    [2];
    logic [31:0]                  r_s     [2];
    logic [tsrf_pkg::PA_W-1:0]    r_pa    [2];
    logic [tsrf_pkg::PRED_W-1:0]  r_pred  [2];
    logic                         r_zero  [2];
    logic [20:0]                  r_t     [2];
    logic [5:0]                   r_n     [2];
    logic [15:0]                  r_f     [2];
    logic [16:0]                  r_h     [2];
    logic [31:0]                  r_e     [2];
    logic [63:0]                  r_u     [2];
    logic [63:0]                  r_prod  [2];
    logic [63:0]                  r_alpha [2];
    logic [63:0]                  r_z;

    // Lane combinational terms
    logic [32:0]                  w_d     [2];
    logic [32:0]                  w_ad    [2];
    logic [31:0]                  w_s     [2];
    logic [tsrf_pkg::PROD_W-1:0]  w_m0    [2];
    logic [tsrf_pkg::PROD_W-1:0]  w_m1    [2];
    logic [37:0]                  w_sq    [2];
    logic [37:0]                  w_y     [2];
    logic [32:0]                  w_hp    [2];
    logic [16:0]                  w_hs    [2];
    logic [32:0]                  w_es    [2];
    tsrf_pkg::t_div_cmd           w_cmd   [2];
    logic                         w_busy  [2];
    logic [tsrf_pkg::DIV_W-1:0]   w_q     [2];

    logic        w_pred_hi;
    logic        w_u_hi;
    logic [15:0] w_p16;
    logic        w_regime;
    logic        w_changed;
    logic [31:0] w_changes_n;
    logic [31:0] w_records_n;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            // Distance to the state mean and guarded deviation
            w_d[j]  = {r_x[31], r_x} - {i_cfg.means[32*j+31], i_cfg.means[32*j +: 32]};
            w_ad[j] = w_d[j][32] ? (33'd0 - w_d[j]) : w_d[j];
            w_s[j]  = (i_cfg.deviations[32*j +: 32] == 32'd0) ? 32'd1
                                                              : i_cfg.deviations[32*j +: 32];
            // Transition products into state j
            w_m0[j] = tsrf_pkg::PROD_W'(r_belief[0]) *
                      tsrf_pkg::PROD_W'(i_cfg.transition[16*j +: 16]);
            w_m1[j] = tsrf_pkg::PROD_W'(r_belief[1]) *
                      tsrf_pkg::PROD_W'(i_cfg.transition[32+16*j +: 16]);
            // Exp approximation steps
            w_sq[j] = 38'(w_q[j][18:0]) * 38'(w_q[j][18:0]);
            w_y[j]  = 38'(r_t[j]) * 38'(tsrf_pkg::LOG2E_Q16);
            w_hp[j] = 33'((i_op == tsrf_pkg::OP_H1) ? tsrf_pkg::EXP_C3 : r_h[j]) * 33'(r_f[j]);
            w_hs[j] = w_hp[j][32:16];
            w_es[j] = {r_h[j], 16'd0} >> r_n[j];
            // Divider commands
            w_cmd[j]       = '0;
            w_cmd[j].start = 1'b0;
            case (i_op)
                tsrf_pkg::OP_ZQ_START: begin
                    w_cmd[j].start    = 1'b1;
                    w_cmd[j].dividend = {r_ad[j], 31'd0};
                    w_cmd[j].divisor  = 64'(r_s[j]);
                    w_cmd[j].steps    = tsrf_pkg::ZQ_STEPS;
                end
                tsrf_pkg::OP_U_START: begin
                    w_cmd[j].start    = 1'b1;
                    w_cmd[j].dividend = {1'b0, r_e[j], 31'd0};
                    w_cmd[j].divisor  = 64'(r_s[j]);
                    w_cmd[j].steps    = tsrf_pkg::U_STEPS;
                end
                tsrf_pkg::OP_F_START: begin
                    w_cmd[j].start    = 1'b1;
                    w_cmd[j].rem_init = r_alpha[j];
                    w_cmd[j].divisor  = r_z;
                    w_cmd[j].steps    = tsrf_pkg::F_STEPS;
                end
                default: begin
                    w_cmd[j].start = 1'b0;
                end
            endcase
        end
    end

    // Two divider lanes, one per state
    for (genvar g = 0; g < 2; g++) begin : g_div
        tsrf_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .o_busy  (w_busy[g]),
            .o_quot  (w_q[g])
        );
    end

    // Common normalizing shift: both values above 32 bits shift together
    always_comb begin
        w_pred_hi = ((r_pred[0] | r_pred[1]) >> 32) != '0;
        w_u_hi    = ((r_u[0] | r_u[1]) >> 32) != '0;
    end

    assign o_status.div_busy  = w_busy[0] | w_busy[1];
    assign o_status.norm_fits = !w_pred_hi && !w_u_hi;

    // Regime decision and saturating counts for the finishing record
    always_comb begin
        w_p16       = w_q[1][F-1 -: 16];
        w_regime    = {1'b0, w_p16} >= i_cfg.threshold;
        w_changed   = (r_records >= 32'(i_cfg.warmup)) && r_last_valid &&
                      (w_regime != r_last_regime);
        w_changes_n = (w_changed && r_changes != '1) ? r_changes + 32'd1 : r_changes;
        w_records_n = (r_records != '1) ? r_records + 32'd1 : r_records;
        if (i_op == tsrf_pkg::OP_RESTART) begin
            o_result = '0;
            o_result.p_bull = tsrf_pkg::P_HALF;
        end else begin
            o_result.p_bull         = w_p16;
            o_result.regime         = w_regime;
            o_result.regime_valid   = 1'b1;
            o_result.regime_changed = w_changed;
            o_result.change_count   = w_changes_n;
            o_result.record_count   = w_records_n;
        end
    end

    // Filter state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_belief[0]   <= '0;
            r_belief[1]   <= '0;
            r_last_regime <= 1'b0;
            r_last_valid  <= 1'b0;
            r_records     <= '0;
            r_changes     <= '0;
        end else if (i_op == tsrf_pkg::OP_RESTART) begin
            r_belief[0]   <= BW'(i_cfg.init_probs[15:0]) << (F - 16);
            r_belief[1]   <= BW'(i_cfg.init_probs[31:16]) << (F - 16);
            r_last_regime <= 1'b0;
            r_last_valid  <= 1'b0;
            r_records     <= '0;
            r_changes     <= '0;
        end else if (i_op == tsrf_pkg::OP_FINISH) begin
            r_belief[0]   <= w_q[0][BW-1:0];
            r_belief[1]   <= w_q[1][BW-1:0];
            r_last_regime <= w_regime;
            r_last_valid  <= 1'b1;
            r_records     <= w_records_n;
            r_changes     <= w_changes_n;
        end
    end

    // Working registers, one step per operation
    always_ff @(posedge i_clk) begin
        if (i_op == tsrf_pkg::OP_LATCH) begin
            r_x <= i_sample;
        end
        if (i_op == tsrf_pkg::OP_ZSUM) begin
            r_z <= r_alpha[0] + r_alpha[1];
        end
        for (int j = 0; j < 2; j++) begin
            case (i_op)
                tsrf_pkg::OP_PRED_A: begin
                    r_pa[j] <= tsrf_pkg::PA_W'(w_m0[j] >> 15);
                    r_ad[j] <= w_ad[j];
                    r_s[j]  <= w_s[j];
                end
                tsrf_pkg::OP_PRED_B: begin
                    r_pred[j] <= tsrf_pkg::PRED_W'(r_pa[j]) +
                                 tsrf_pkg::PRED_W'(w_m1[j] >> 15);
                end
                tsrf_pkg::OP_EXP_T: begin
                    // z of 8.0 or more gives a zero exp term
                    r_zero[j] <= w_q[j][63:19] != '0;
                    r_t[j]    <= w_sq[j][37:17];
                end
                tsrf_pkg::OP_EXP_Y: begin
                    r_n[j] <= w_y[j][37:32];
                    r_f[j] <= w_y[j][31:16];
                end
                tsrf_pkg::OP_H1: r_h[j] <= tsrf_pkg::EXP_C2 - w_hs[j];
                tsrf_pkg::OP_H2: r_h[j] <= tsrf_pkg::EXP_C1 - w_hs[j];
                tsrf_pkg::OP_H3: r_h[j] <= tsrf_pkg::EXP_ONE - w_hs[j];
                tsrf_pkg::OP_EXP_E: begin
                    if (r_zero[j]) begin
                        r_e[j] <= '0;
                    end else begin
                        r_e[j] <= w_es[j][32] ? 32'hFFFF_FFFF : w_es[j][31:0];
                    end
                end
                tsrf_pkg::OP_U_CAP: r_u[j] <= w_q[j];
                tsrf_pkg::OP_NORM: begin
                    if (w_pred_hi) begin
                        r_pred[j] <= r_pred[j] >> 1;
                    end
                    if (w_u_hi) begin
                        r_u[j] <= r_u[j] >> 1;
                    end
                end
                tsrf_pkg::OP_ALPHA: begin
                    r_prod[j] <= 64'(32'(r_pred[j])) * 64'(r_u[j][31:0]);
                end
                tsrf_pkg::OP_ALPHA_ADD: begin
                    r_alpha[j] <= {1'b0, r_prod[j][63:1]} + 64'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // A normalized pair of beliefs never exceeds one in total
    a_belief_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == tsrf_pkg::OP_FINISH) |=>
            ((BW+1)'(r_belief[0]) + (BW+1)'(r_belief[1])) <= ((BW+1)'(1) << F))
        else $error("beliefs sum above one");

endmodule

### hdl/tsrf_ctrl.sv
// Sequencer: steps one record through the datapath
module tsrf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_action,
    input  logic                 i_out_free,
    input  tsrf_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output logic                 o_load,
    output tsrf_pkg::t_dp_op     o_op
);

    tsrf_pkg::t_state r_state;
    tsrf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsrf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_op       = tsrf_pkg::OP_NONE;
        o_load     = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            tsrf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = tsrf_pkg::OP_LATCH;
                    n_state = i_action ? tsrf_pkg::ST_RESTART : tsrf_pkg::ST_PRED_A;
                end
            end
            tsrf_pkg::ST_RESTART: begin
                if (i_out_free) begin
                    o_op    = tsrf_pkg::OP_RESTART;
                    o_load  = 1'b1;
                    n_state = tsrf_pkg::ST_IDLE;
                end
            end
            tsrf_pkg::ST_PRED_A: begin
                o_op    = tsrf_pkg::OP_PRED_A;
                n_state = tsrf_pkg::ST_PRED_B;
            end
            tsrf_pkg::ST_PRED_B: begin
                o_op    = tsrf_pkg::OP_PRED_B;
                n_state = tsrf_pkg::ST_ZQ_START;
            end
            tsrf_pkg::ST_ZQ_START: begin
                o_op    = tsrf_pkg::OP_ZQ_START;
                n_state = tsrf_pkg::ST_ZQ_WAIT;
            end
            tsrf_pkg::ST_ZQ_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = tsrf_pkg::ST_EXP_T;
                end
            end
            tsrf_pkg::ST_EXP_T: begin
                o_op    = tsrf_pkg::OP_EXP_T;
                n_state = tsrf_pkg::ST_EXP_Y;
            end
            tsrf_pkg::ST_EXP_Y: begin
                o_op    = tsrf_pkg::OP_EXP_Y;
                n_state = tsrf_pkg::ST_H1;
            end
            tsrf_pkg::ST_H1: begin
                o_op    = tsrf_pkg::OP_H1;
                n_state = tsrf_pkg::ST_H2;
            end
            tsrf_pkg::ST_H2: begin
                o_op    = tsrf_pkg::OP_H2;
                n_state = tsrf_pkg::ST_H3;
            end
            tsrf_pkg::ST_H3: begin
                o_op    = tsrf_pkg::OP_H3;
                n_state = tsrf_pkg::ST_EXP_E;
            end
            tsrf_pkg::ST_EXP_E: begin
                o_op    = tsrf_pkg::OP_EXP_E;
                n_state = tsrf_pkg::ST_U_START;
            end
            tsrf_pkg::ST_U_START: begin
                o_op    = tsrf_pkg::OP_U_START;
                n_state = tsrf_pkg::ST_U_WAIT;
            end
            tsrf_pkg::ST_U_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = tsrf_pkg::ST_U_CAP;
                end
            end
            tsrf_pkg::ST_U_CAP: begin
                o_op    = tsrf_pkg::OP_U_CAP;
                n_state = tsrf_pkg::ST_NORM;
            end
            tsrf_pkg::ST_NORM: begin
                if (i_status.norm_fits) begin
                    n_state = tsrf_pkg::ST_ALPHA;
                end else begin
                    o_op = tsrf_pkg::OP_NORM;
                end
            end
            tsrf_pkg::ST_ALPHA: begin
                o_op    = tsrf_pkg::OP_ALPHA;
                n_state = tsrf_pkg::ST_ALPHA_ADD;
            end
            tsrf_pkg::ST_ALPHA_ADD: begin
                o_op    = tsrf_pkg::OP_ALPHA_ADD;
                n_state = tsrf_pkg::ST_ZSUM;
            end
            tsrf_pkg::ST_ZSUM: begin
                o_op    = tsrf_pkg::OP_ZSUM;
                n_state = tsrf_pkg::ST_F_START;
            end
            tsrf_pkg::ST_F_START: begin
                o_op    = tsrf_pkg::OP_F_START;
                n_state = tsrf_pkg::ST_F_WAIT;
            end
            tsrf_pkg::ST_F_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = tsrf_pkg::ST_FINISH;
                end
            end
            tsrf_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    o_op    = tsrf_pkg::OP_FINISH;
                    o_load  = 1'b1;
                    n_state = tsrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsrf_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is only produced by a finish or restart step
    a_load_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> (o_op == tsrf_pkg::OP_FINISH || o_op == tsrf_pkg::OP_RESTART))
        else $error("result load without finishing step");

endmodule

### hdl/two_state_regime_filter_top.sv
// Two-state regime filter. Each input transaction carries a signed Q16.16 sample in
// s_axis_tdata and an action in s_axis_tuser (0 record the sample, 1 restart from the
// initial probabilities and clear the counts); each one yields exactly one result
// transaction on m_axis. Items are processed one at a time: a record passes through two
// bit-serial divider lanes that run 49 steps for z, 64 steps for the reciprocal weight
// and 32 steps for the normalized beliefs, and its weights are shifted one bit per cycle
// until they fit 32 bits; its result also waits while the previous result is still held
// in the output register. A restart loads its result from the restart state once the
// output register is free. The next item is accepted while a finished result still
// waits in the output register. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce it.
module two_state_regime_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [tsrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample
    input  logic        s_axis_tuser,   // [0] action
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [15:0] p_bull, [16] regime, [17] regime_valid,
                                        // [18] regime_changed, [50:19] change_count,
                                        // [82:51] record_count, [87:83] zero
);

    tsrf_pkg::t_cfg       r_cfg;
    tsrf_pkg::t_dp_status w_status;
    tsrf_pkg::t_result    w_result;
    tsrf_pkg::t_dp_op     w_op;
    logic                 w_load;
    logic                 w_out_free;
    logic                 r_out_valid;
    tsrf_pkg::t_result    r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg           <= '0;
            r_cfg.threshold <= tsrf_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsrf_pkg::CFG_TRANSITION: r_cfg.transition <= i_cfg_data;
                tsrf_pkg::CFG_MEANS:      r_cfg.means      <= i_cfg_data;
                tsrf_pkg::CFG_DEVIATIONS: r_cfg.deviations <= i_cfg_data;
                tsrf_pkg::CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[16:0];
                tsrf_pkg::CFG_WARMUP:     r_cfg.warmup     <= i_cfg_data[15:0];
                tsrf_pkg::CFG_INIT_PROBS: r_cfg.init_probs <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    tsrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_load     (w_load),
        .o_op       (w_op)
    );

    tsrf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_sample (s_axis_tdata),
        .i_cfg    (r_cfg),
        .o_status (w_status),
        .o_result (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten before transfer");

endmodule

### verif/two_state_regime_filter_top_tb.sv
module two_state_regime_filter_top_tb;

    localparam int FB = tsrf_pkg::BELIEF_FRAC_BITS;
    localparam int N_RANDOM = 1850;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;

    two_state_regime_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Filter shadow: configuration and state
    logic [63:0] f_trans, f_means, f_devs;
    logic [16:0] f_thr;
    logic [15:0] f_warm;
    logic [31:0] f_init;
    logic [63:0] f_bel [2];
    logic        f_last, f_last_ok;
    logic [31:0] f_recs, f_chgs;

    tsrf_pkg::t_result regime_q[$];
    int          err_cnt;
    int          cyc;
    bit          quiet;      // no idling in the final part
    bit          hold_rx;    // long receiver hold-off request
    int          rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int fit_shift(input logic [63:0] m);
        int b;
        b = 0;
        while (m != 0) begin
            b++;
            m = m >> 1;
        end
        return (b > 32) ? b - 32 : 0;
    endfunction

    function automatic logic [63:0] gauss_weight(input logic signed [31:0] x, input int j);
        logic signed [63:0] mu, d;
        logic [63:0] s, ad, zq, t, y, n, f, h, e;
        mu = 64'(signed'(f_means[32*j +: 32]));
        s  = {32'd0, f_devs[32*j +: 32]};
        if (s == 0) s = 1;
        d  = 64'(x) - mu;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        zq = (ad << 16) / s;
        if (zq >= (64'd8 << 16)) return 64'd0;
        t = (zq * zq) >> 17;
        y = (t * 64'd94548) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        h = 64'd15743 - ((64'd3638 * f) >> 16);
        h = 64'd45426 - ((h * f) >> 16);
        h = 64'd65536 - ((h * f) >> 16);
        if (n >= 48) e = 0;
        else begin
            e = (h << 16) >> n;
            if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
        end
        return (e << 31) / s;
    endfunction

    function automatic logic [63:0] belief_div(input logic [63:0] a, input logic [63:0] z);
        logic [63:0] rem, q;
        logic carry;
        rem = a;
        q = 0;
        for (int i = 0; i < FB; i++) begin
            carry = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (carry || rem >= z) begin
                rem = rem - z;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic tsrf_pkg::t_result filter_step(input logic act, input logic [31:0] smp);
        tsrf_pkg::t_result r;
        logic [63:0] pred[2], u[2], alpha[2], a0, a1, z, mx;
        logic [15:0] p16;
        logic rg, chg;
        int sh;
        r = '0;
        if (act) begin
            f_bel[0] = 64'(f_init[15:0]) << (FB - 16);
            f_bel[1] = 64'(f_init[31:16]) << (FB - 16);
            f_last = 0; f_last_ok = 0; f_recs = 0; f_chgs = 0;
            r.p_bull = tsrf_pkg::P_HALF;
            return r;
        end
        for (int j = 0; j < 2; j++) begin
            a0 = 64'(f_trans[16*j +: 16]);
            a1 = 64'(f_trans[16*(2+j) +: 16]);
            pred[j] = ((f_bel[0] * a0) >> 15) + ((f_bel[1] * a1) >> 15);
            u[j] = gauss_weight(smp, j);
        end
        mx = (pred[0] > pred[1]) ? pred[0] : pred[1];
        sh = fit_shift(mx);
        pred[0] = pred[0] >> sh; pred[1] = pred[1] >> sh;
        mx = (u[0] > u[1]) ? u[0] : u[1];
        sh = fit_shift(mx);
        u[0] = u[0] >> sh; u[1] = u[1] >> sh;
        for (int j = 0; j < 2; j++) alpha[j] = ((pred[j] * u[j]) >> 1) + 1;
        z = alpha[0] + alpha[1];
        f_bel[0] = belief_div(alpha[0], z);
        f_bel[1] = belief_div(alpha[1], z);
        p16 = f_bel[1][FB-1 -: 16];
        rg = (17'(p16) >= f_thr);
        chg = 0;
        if (f_recs >= 32'(f_warm) && f_last_ok && rg != f_last) begin
            chg = 1;
            if (f_chgs != 32'hFFFF_FFFF) f_chgs++;
        end
        f_last = rg; f_last_ok = 1;
        if (f_recs != 32'hFFFF_FFFF) f_recs++;
        r.p_bull = p16; r.regime = rg; r.regime_valid = 1;
        r.regime_changed = chg; r.change_count = f_chgs; r.record_count = f_recs;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cyc);
        err_cnt++;
    endtask

    // Configuration writes, only while idle
    task automatic cfg_write(input tsrf_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tsrf_pkg::CFG_TRANSITION: f_trans = val;
            tsrf_pkg::CFG_MEANS:      f_means = val;
            tsrf_pkg::CFG_DEVIATIONS: f_devs = val;
            tsrf_pkg::CFG_THRESHOLD:  f_thr = val[16:0];
            tsrf_pkg::CFG_WARMUP:     f_warm = val[15:0];
            tsrf_pkg::CFG_INIT_PROBS: f_init = val[31:0];
            default: ;
        endcase
    endtask

    // Sender stops offering and waits for every outstanding result
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (regime_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Send one transaction; predicted when accepted
    task automatic send_item(input logic act, input logic [31:0] smp,
                             input bit typed, input tsrf_pkg::t_result want);
        tsrf_pkg::t_result p;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        p = filter_step(act, smp);
        if (typed) p = want;
        regime_q.push_back(p);
    endtask

    // Receiver side: random stalls, plus one long hold-off
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        rx_hold_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx && rx_hold_cycles < 600) begin
                rx_hold_cycles++;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        tsrf_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = tsrf_pkg::t_result'(m_axis_tdata[82:0]);
            if (regime_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(got), 64'd0);
            end else begin
                want = regime_q.pop_front();
                if (got.p_bull != want.p_bull)
                    report_mismatch("p_bull", 64'(got.p_bull), 64'(want.p_bull));
                if (got.regime != want.regime)
                    report_mismatch("regime", 64'(got.regime), 64'(want.regime));
                if (got.regime_valid != want.regime_valid)
                    report_mismatch("regime_valid", 64'(got.regime_valid),
                                    64'(want.regime_valid));
                if (got.regime_changed != want.regime_changed)
                    report_mismatch("regime_changed", 64'(got.regime_changed),
                                    64'(want.regime_changed));
                if (got.change_count != want.change_count)
                    report_mismatch("change_count", 64'(got.change_count),
                                    64'(want.change_count));
                if (got.record_count != want.record_count)
                    report_mismatch("record_count", 64'(got.record_count),
                                    64'(want.record_count));
            end
        end
    end

    // Watchdog
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= CYCLE_LIMIT) begin
                $display("two_state_regime_filter_top verification failed");
                $finish;
            end
        end
    end

    typedef struct {
        logic              act;
        logic [31:0]       smp;
        bit                typed;
        tsrf_pkg::t_result want;
    } t_stim_row;

    function automatic tsrf_pkg::t_result restart_result();
        tsrf_pkg::t_result r;
        r = '0;
        r.p_bull = tsrf_pkg::P_HALF;
        return r;
    endfunction

    function automatic logic [31:0] rand_sample(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic random_config(input int phase);
        logic [15:0] p0, p1;
        cfg_write(tsrf_pkg::CFG_TRANSITION, (phase % 4 == 0) ? {$urandom(), $urandom()} :
                  {16'($urandom_range(20000, 32768)), 16'($urandom_range(0, 12000)),
                   16'($urandom_range(0, 12000)), 16'($urandom_range(20000, 32768))});
        cfg_write(tsrf_pkg::CFG_MEANS, (phase % 5 == 0) ? {$urandom(), $urandom()} :
                  {32'($urandom_range(0, 3 << 16)), 32'(-$signed($urandom_range(0, 3 << 16)))});
        cfg_write(tsrf_pkg::CFG_DEVIATIONS, (phase % 6 == 0) ? {$urandom(), $urandom()} :
                  {32'($urandom_range(1, 4 << 16)), 32'($urandom_range(1, 4 << 16))});
        case (phase % 4)
            0: cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'(0));
            1: cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'(65536));
            2: cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'($urandom_range(0, 131071)));
            default: cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'($urandom_range(20000, 45000)));
        endcase
        cfg_write(tsrf_pkg::CFG_WARMUP, (phase % 3 == 0) ? 64'($urandom_range(0, 65535)) :
                  64'($urandom_range(0, 12)));
        p0 = $urandom(); p1 = $urandom();
        cfg_write(tsrf_pkg::CFG_INIT_PROBS, {32'd0, p1, p0});
    endtask

    initial begin
        t_stim_row rows[$];
        int mode;
        err_cnt = 0;
        quiet = 0;
        hold_rx = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        f_trans = 0; f_means = 0; f_devs = 0; f_thr = tsrf_pkg::THR_RESET; f_warm = 0;
        f_init = 0;
        f_bel[0] = 0; f_bel[1] = 0; f_last = 0; f_last_ok = 0; f_recs = 0; f_chgs = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: records straight from reset (all beliefs zero), then extremes
        rows.push_back('{1'b0, 32'h0000_0000, 0, '0});
        rows.push_back('{1'b0, 32'h7FFF_FFFF, 0, '0});
        rows.push_back('{1'b1, 32'h0, 1, restart_result()});
        rows.push_back('{1'b0, 32'h8000_0000, 0, '0});
        rows.push_back('{1'b1, 32'hFFFF_FFFF, 1, restart_result()});
        foreach (rows[i]) send_item(rows[i].act, rows[i].smp, rows[i].typed, rows[i].want);
        drain_results();

        cfg_write(tsrf_pkg::CFG_TRANSITION, 64'h7000_1000_1000_7000);
        cfg_write(tsrf_pkg::CFG_MEANS, {32'h0001_0000, 32'hFFFF_0000});
        cfg_write(tsrf_pkg::CFG_DEVIATIONS, {32'h0, 32'h0001_0000});
        cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'(0));
        cfg_write(tsrf_pkg::CFG_WARMUP, 64'(2));
        cfg_write(tsrf_pkg::CFG_INIT_PROBS, 64'hFFFF_0000);
        rows.delete();
        rows.push_back('{1'b1, 32'h0, 1, restart_result()});
        rows.push_back('{1'b0, 32'h0001_0000, 0, '0});
        rows.push_back('{1'b0, 32'hFFFF_0000, 0, '0});
        rows.push_back('{1'b0, 32'h0000_0001, 0, '0});
        rows.push_back('{1'b0, 32'h7FFF_FFFF, 0, '0});
        rows.push_back('{1'b0, 32'h8000_0000, 0, '0});
        foreach (rows[i]) send_item(rows[i].act, rows[i].smp, rows[i].typed, rows[i].want);
        drain_results();
        cfg_write(tsrf_pkg::CFG_THRESHOLD, 64'(65536));
        cfg_write(tsrf_pkg::CFG_TRANSITION, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(tsrf_pkg::CFG_DEVIATIONS, 64'hFFFF_FFFF_FFFF_FFFF);
        rows.delete();
        rows.push_back('{1'b0, 32'h0001_0000, 0, '0});
        rows.push_back('{1'b0, 32'hFFFF_0000, 0, '0});
        rows.push_back('{1'b1, 32'h0, 1, restart_result()});
        rows.push_back('{1'b0, 32'h0, 0, '0});
        foreach (rows[i]) send_item(rows[i].act, rows[i].smp, rows[i].typed, rows[i].want);
        drain_results();

        // Random phases
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0) begin
                drain_results();
                random_config(n / 150);
                mode = $urandom_range(0, 2);
            end
            if (n == 300) hold_rx = 1;
            if (n == 700) begin
                // sender waits for every outstanding result
                s_axis_tvalid <= 1'b0;
                while (regime_q.size() != 0) @(posedge i_clk);
            end
            if (n >= N_RANDOM - 200) quiet = 1;
            if ($urandom_range(0, 29) == 0)
                send_item(1'b1, $urandom(), 0, '0);
            else
                send_item(1'b0, ($urandom_range(0, 9) == 0) ? $urandom() : rand_sample(mode),
                          0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (regime_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("two_state_regime_filter_top verification clean");
        end else begin
            $display("two_state_regime_filter_top verification failed");
        end
        $finish;
    end

endmodule
